// ----- design/matrix_multiply_3x3_assert.svh -----
// assertion macros for the 3x3 matrix multiplier
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef MATRIX_MULTIPLY_3X3_ASSERT_SVH
`define MATRIX_MULTIPLY_3X3_ASSERT_SVH
`ifndef SYNTHESIS
`define MM3_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mm3 assertion failed");
`define MM3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mm3 assertion failed");
`else
`define MM3_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MM3_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/mm3_pkg.sv -----
// shared types and constants for the 3x3 matrix multiplier
// no dependencies
package mm3_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int ACC_W         = PROD_W + 2;
   localparam int STORE_DEPTH   = 9;
   localparam int ADDR_W        = 4;
   localparam int IDX_W         = 2;
   localparam logic [IDX_W-1:0] LAST_IDX = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctl_type;
endpackage

// ----- design/mm3_mac.sv -----
// shared multiply-accumulate unit with floor shift and 32-bit saturation
// depends on mm3_pkg
module mm3_mac import mm3_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  mac_ctl_type              ctl,
   input  logic signed [DATA_W-1:0] op_a,
   input  logic signed [DATA_W-1:0] op_b,
   output logic signed [DATA_W-1:0] sat_value
);
   localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (DATA_W - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (DATA_W - 1));

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  shifted;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (ctl.acc_en) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign shifted = acc_ff >>> FRAC_BITS;

   always_comb begin
      if (shifted > SAT_HI) begin
         sat_value = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (shifted < SAT_LO) begin
         sat_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_value = shifted[DATA_W-1:0];
      end
   end
endmodule

// ----- design/matrix_multiply_3x3.sv -----
// 3x3 fixed-point matrix multiplier, top level; depends on mm3_pkg, mm3_mac
// and matrix_multiply_3x3_assert.svh. an element beat without compute is
// written without leaving idle. with compute, busy stays high while the nine
// outputs each take three multiply and three accumulate passes of the one
// shared mac plus an emit state, whose result is registered onto the strobe.
// synchronous reset clears both stores, the sequencer and the strobe.
`include "matrix_multiply_3x3_assert.svh"
module matrix_multiply_3x3 import mm3_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_element_value,
   input  logic                     req_operand_sel,
   input  logic [IDX_W-1:0]         req_row_index,
   input  logic [IDX_W-1:0]         req_col_index,
   input  logic                     req_compute_now,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_product_value,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic                     rsp_last_of_run
);
   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        row_ff, row_in;
   logic [IDX_W-1:0]        col_ff, col_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic signed [DATA_W-1:0] left_ff  [STORE_DEPTH];
   logic signed [DATA_W-1:0] right_ff [STORE_DEPTH];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [IDX_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic                    rsp_last_ff;
   logic                    write_en;
   logic [ADDR_W-1:0]       write_addr;
   logic [ADDR_W-1:0]       left_addr, right_addr;
   logic signed [DATA_W-1:0] sat_value;
   mac_ctl_type             ctl;

   assign write_addr = (ADDR_W'(req_row_index) << 1) + ADDR_W'(req_row_index)
                       + ADDR_W'(req_col_index);
   assign left_addr  = (ADDR_W'(row_ff) << 1) + ADDR_W'(row_ff) + ADDR_W'(k_ff);
   assign right_addr = (ADDR_W'(k_ff) << 1) + ADDR_W'(k_ff) + ADDR_W'(col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            left_ff[i]  <= '0;
            right_ff[i] <= '0;
         end
      end else if (write_en) begin
         if (req_operand_sel) begin
            right_ff[write_addr] <= req_element_value;
         end else begin
            left_ff[write_addr] <= req_element_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT) begin
         rsp_value_ff <= sat_value;
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
         rsp_last_ff  <= (row_ff == LAST_IDX) && (col_ff == LAST_IDX);
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      ctl          = '0;
      rsp_valid_in = 1'b0;
      write_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               write_en = (req_row_index <= LAST_IDX) && (req_col_index <= LAST_IDX);
               if (req_compute_now) begin
                  state_in  = ST_MUL;
                  row_in    = '0;
                  col_in    = '0;
                  k_in      = '0;
                  ctl.clear = 1'b1;
               end
            end
         end
         ST_MUL: begin
            ctl.mul_en = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            ctl.acc_en = 1'b1;
            if (k_ff == LAST_IDX) begin
               state_in = ST_EMIT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            ctl.clear    = 1'b1;
            k_in         = '0;
            if (col_ff == LAST_IDX) begin
               col_in = '0;
               if (row_ff == LAST_IDX) begin
                  row_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   mm3_mac #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mac (
      .clock    (clock),
      .ctl      (ctl),
      .op_a     (left_ff[left_addr]),
      .op_b     (right_ff[right_addr]),
      .sat_value(sat_value)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   // last beat of a run is always the bottom-right element
   `MM3_ASSERT_IMPLY(a_last_corner, clock, reset, rsp_valid && rsp_last_of_run, rsp_out_row == LAST_IDX && rsp_out_col == LAST_IDX)
   // a compute request makes the block busy
   `MM3_ASSERT_NEXT(a_compute_busy, clock, reset, start && !busy && req_compute_now, busy)
   // every strobe comes from an emit cycle
   `MM3_ASSERT_IMPLY(a_strobe_src, clock, reset, rsp_valid, $past(state_ff) == ST_EMIT)
   // the accumulate count never passes the last index
   `MM3_ASSERT_IMPLY(a_k_range, clock, reset, state_ff == ST_ACC, k_ff <= LAST_IDX)
endmodule

// ----- verif/matrix_multiply_3x3_tb.sv -----
// self-checking testbench for the 3x3 fixed-point matrix multiplier
// depends on mm3_pkg and matrix_multiply_3x3; predicts each product beat and
// compares it field by field as it is strobed out
`timescale 1ns / 1ps
module matrix_multiply_3x3_tb;
   import mm3_pkg::*;

   localparam logic                     SEL_LEFT  = 1'b0;
   localparam logic                     SEL_RIGHT = 1'b1;
   localparam logic [IDX_W-1:0]         BAD_IDX   = 2'd3;
   localparam logic signed [DATA_W-1:0] FIX_ONE   = 32'sd1 <<< FRAC_BITS_DEF;
   localparam logic signed [DATA_W-1:0] VAL_MAX   = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] VAL_MIN   = 32'sh8000_0000;
   localparam logic signed [ACC_W-1:0]  SAT_HI    = 66'sd2147483647;
   localparam logic signed [ACC_W-1:0]  SAT_LO    = -66'sd2147483648;
   localparam int                       DRAIN_CYCLES = 80;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic                     last;
   } product_beat_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [DATA_W-1:0] req_element_value = '0;
   logic                     req_operand_sel = 1'b0;
   logic [IDX_W-1:0]         req_row_index = '0;
   logic [IDX_W-1:0]         req_col_index = '0;
   logic                     req_compute_now = 1'b0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_product_value;
   logic [IDX_W-1:0]         rsp_out_row;
   logic [IDX_W-1:0]         rsp_out_col;
   logic                     rsp_last_of_run;

   product_beat_type         pending_products[$];
   logic signed [DATA_W-1:0] left_mat[STORE_DEPTH];
   logic signed [DATA_W-1:0] right_mat[STORE_DEPTH];
   int                       err_count = 0;
   int                       item_count = 0;
   int                       compute_count = 0;
   int                       product_count = 0;
   bit                       idle_enable = 1'b1;

   matrix_multiply_3x3 #(.FRAC_BITS(FRAC_BITS_DEF)) uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_element_value (req_element_value),
      .req_operand_sel   (req_operand_sel),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_compute_now   (req_compute_now),
      .rsp_valid         (rsp_valid),
      .rsp_product_value (rsp_product_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // full-width dot product, floor shift, saturate to 32 bits
   function automatic logic signed [DATA_W-1:0] dot_entry(input int r, input int c);
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] shifted;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         acc = acc + left_mat[r*3+k] * right_mat[k*3+c];
      end
      shifted = acc >>> FRAC_BITS_DEF;
      if (shifted > SAT_HI) return VAL_MAX;
      if (shifted < SAT_LO) return VAL_MIN;
      return shifted[DATA_W-1:0];
   endfunction

   task automatic store_and_predict(input logic signed [DATA_W-1:0] v, input logic sel,
                                    input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                    input logic cmp);
      product_beat_type beat;
      if (r != BAD_IDX && c != BAD_IDX) begin
         if (sel == SEL_RIGHT) right_mat[r*3+c] = v;
         else left_mat[r*3+c] = v;
      end
      if (cmp) begin
         compute_count++;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               beat.value = dot_entry(i, j);
               beat.row   = IDX_W'(i);
               beat.col   = IDX_W'(j);
               beat.last  = (i == 2 && j == 2);
               pending_products.push_back(beat);
            end
         end
      end
   endtask

   task automatic send_element(input logic signed [DATA_W-1:0] v, input logic sel,
                               input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                               input logic cmp);
      if (idle_enable && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start             <= 1'b1;
      req_element_value <= v;
      req_operand_sel   <= sel;
      req_row_index     <= r;
      req_col_index     <= c;
      req_compute_now   <= cmp;
      @(posedge clock);
      while (busy) @(posedge clock);
      store_and_predict(v, sel, r, c, cmp);
      item_count++;
   endtask

   function automatic logic signed [DATA_W-1:0] rand_element();
      case ($urandom_range(0, 6))
         0: return $urandom;
         1: return VAL_MAX;
         2: return VAL_MIN;
         3: return $signed($urandom_range(0, 2**20)) - (2**19);
         4: return $signed($urandom_range(0, 6)) - 3;
         default: return $signed($urandom_range(0, 2**24)) - (2**23);
      endcase
   endfunction

   // writes then a compute on the final beat
   task automatic load_and_compute(input bit full_reload);
      int n;
      if (full_reload) begin
         for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
               send_element(rand_element(), s[0], IDX_W'(i / 3), IDX_W'(i % 3),
                            s == 1 && i == STORE_DEPTH - 1);
            end
         end
      end else begin
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++) begin
            send_element(rand_element(), 1'($urandom_range(0, 1)),
                         IDX_W'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 2)),
                         i == n - 1);
         end
      end
   endtask

   task automatic test_reset_stores();
      send_element('0, SEL_LEFT, 2'd0, 2'd0, 1'b1);
   endtask

   task automatic test_saturation();
      send_element(VAL_MIN, SEL_LEFT, 2'd0, 2'd0, 1'b0);
      send_element(VAL_MIN, SEL_RIGHT, 2'd0, 2'd0, 1'b1);
      send_element(VAL_MAX, SEL_RIGHT, 2'd0, 2'd0, 1'b1);
   endtask

   task automatic test_ignored_writes();
      send_element(32'shffff_ffff, SEL_RIGHT, BAD_IDX, BAD_IDX, 1'b1);
      send_element(VAL_MAX, SEL_LEFT, BAD_IDX, 2'd0, 1'b0);
      send_element(VAL_MAX, SEL_LEFT, 2'd0, BAD_IDX, 1'b1);
   endtask

   task automatic test_identity_reuse();
      send_element(FIX_ONE, SEL_LEFT, 2'd0, 2'd0, 1'b0);
      send_element(FIX_ONE, SEL_LEFT, 2'd1, 2'd1, 1'b0);
      send_element(FIX_ONE, SEL_LEFT, 2'd2, 2'd2, 1'b0);
      send_element(32'sh0003_8000, SEL_RIGHT, 2'd1, 2'd2, 1'b0);
      send_element(-32'sh0002_4000, SEL_RIGHT, 2'd2, 2'd1, 1'b1);
      send_element(32'sh0000_c000, SEL_RIGHT, 2'd2, 2'd0, 1'b1);
   endtask

   // negative sums below one lsb must floor, not truncate toward zero
   task automatic test_floor();
      send_element(-32'sd1, SEL_LEFT, 2'd0, 2'd1, 1'b0);
      send_element(32'sd1, SEL_RIGHT, 2'd1, 2'd0, 1'b1);
   endtask

   task automatic test_random_runs();
      while (item_count < 320) load_and_compute($urandom_range(0, 2) == 0);
   endtask

   task automatic test_random_noise();
      for (int i = 0; i < 80; i++) begin
         send_element(rand_element(), 1'($urandom_range(0, 1)),
                      IDX_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
                      $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic test_back_to_back();
      idle_enable = 1'b0;
      while (item_count < 460) load_and_compute($urandom_range(0, 3) == 0);
   endtask

   always @(posedge clock) begin : check_products
      product_beat_type want;
      if (!reset && rsp_valid) begin
         product_count++;
         if (pending_products.size() == 0) begin
            err_count++;
            $display("%0t: unexpected product beat value=%0d row=%0d col=%0d last=%0b",
                     $time, rsp_product_value, rsp_out_row, rsp_out_col, rsp_last_of_run);
         end else begin
            want = pending_products.pop_front();
            if (rsp_product_value !== want.value) begin
               err_count++;
               $display("%0t: product_value expected %0d actual %0d", $time,
                        want.value, rsp_product_value);
            end
            if (rsp_out_row !== want.row) begin
               err_count++;
               $display("%0t: out_row expected %0d actual %0d", $time, want.row, rsp_out_row);
            end
            if (rsp_out_col !== want.col) begin
               err_count++;
               $display("%0t: out_col expected %0d actual %0d", $time, want.col, rsp_out_col);
            end
            if (rsp_last_of_run !== want.last) begin
               err_count++;
               $display("%0t: last_of_run expected %0b actual %0b", $time,
                        want.last, rsp_last_of_run);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("matrix_multiply_3x3 verification failed");
      $finish;
   end

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         left_mat[i]  = '0;
         right_mat[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_stores();
      test_saturation();
      test_ignored_writes();
      test_identity_reuse();
      test_floor();
      test_random_runs();
      test_random_noise();
      test_back_to_back();
      start <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_products.size() != 0) err_count++;
      $display("%0d element beats, %0d compute requests, %0d product beats checked",
               item_count, compute_count, product_count);
      $display("saturation both ways, floor rounding, ignored index three, operand reuse");
      if (err_count == 0) begin
         $display("matrix_multiply_3x3 verification clean");
      end else begin
         $display("matrix_multiply_3x3 verification failed");
      end
      $finish;
   end
endmodule
